@@ design/tsfc_pkg.sv @@
// ----------------------------------------------------------------------------
// tsfc_pkg: shared types and constants for the touch sample filter
// Channel and register codes, cell control, sequencer states, size limiter.
// ----------------------------------------------------------------------------
package tsfc_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int SAMPLE_LSB  = 3;
    localparam int REPLY_W     = 16;
    localparam int CHAN_W      = 2;
    localparam int PRESS_W     = 13;
    localparam int COORD_W     = 11;
    localparam int CFG_W       = 13;
    localparam int REG_IDX_W   = 3;
    localparam int FLAGS_W     = 3;
    localparam int DIVIDEND_W  = 23;
    localparam int DIVISOR_W   = 12;
    localparam int SAMPLES_DEF = 8;
    localparam int SCREEN_MAX  = 2048;
    localparam int PRESS_BIAS  = 4096;

    localparam logic [SAMPLE_W-1:0] X_ORIGIN_RST = 12'd240;
    localparam logic [SAMPLE_W-1:0] Y_ORIGIN_RST = 12'd285;
    localparam logic [SAMPLE_W-1:0] X_SPAN_RST   = 12'd3600;
    localparam logic [SAMPLE_W-1:0] Y_SPAN_RST   = 12'd3680;
    localparam logic [SAMPLE_W-1:0] WIDTH_RST    = 12'd320;
    localparam logic [SAMPLE_W-1:0] HEIGHT_RST   = 12'd240;
    localparam logic [FLAGS_W-1:0]  FLAGS_RST    = 3'd4;
    localparam logic [PRESS_W-1:0]  THRESH_RST   = 13'd100;

    typedef enum logic [CHAN_W-1:0] {
        CH_X  = 2'd0,
        CH_Y  = 2'd1,
        CH_Z1 = 2'd2,
        CH_Z2 = 2'd3
    } t_channel;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_X_ORIGIN = 3'd0,
        REG_Y_ORIGIN = 3'd1,
        REG_X_SPAN   = 3'd2,
        REG_Y_SPAN   = 3'd3,
        REG_WIDTH    = 3'd4,
        REG_HEIGHT   = 3'd5,
        REG_FLAGS    = 3'd6,
        REG_THRESH   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic shift;
        logic load;
        logic sort;
        logic drain;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT,
        S_DRAIN,
        S_DGO,
        S_DWAIT,
        S_MUL,
        S_FIN
    } t_state;

    typedef enum logic {
        OP_SX,
        OP_SY
    } t_op;

    // Limit a screen dimension to 1 .. SCREEN_MAX
    function automatic logic [SAMPLE_W-1:0] fit_size(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] r;
        if (s == '0) begin
            r = SAMPLE_W'(1);
        end else if (s > SAMPLE_W'(SCREEN_MAX)) begin
            r = SAMPLE_W'(SCREEN_MAX);
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

@@ design/tsfc_cell.sv @@
// ----------------------------------------------------------------------------
// tsfc_cell: one sample cell
// Holds one stored sample and one sort slot; compare-exchanges with a
// neighbour during sorting and shifts towards the end of the row on drain.
// ----------------------------------------------------------------------------
module tsfc_cell (
    input  logic                           i_clk,
    input  tsfc_pkg::t_cell_ctl            i_ctl,
    input  logic                           i_lower,
    input  logic [tsfc_pkg::SAMPLE_W-1:0]  i_store_in,
    input  logic [tsfc_pkg::SAMPLE_W-1:0]  i_left_sort,
    input  logic [tsfc_pkg::SAMPLE_W-1:0]  i_right_sort,
    output logic [tsfc_pkg::SAMPLE_W-1:0]  o_store,
    output logic [tsfc_pkg::SAMPLE_W-1:0]  o_sort
);
    import tsfc_pkg::*;

    logic [SAMPLE_W-1:0] r_store;
    logic [SAMPLE_W-1:0] r_sort;
    logic [SAMPLE_W-1:0] n_sort;

    always_comb begin
        n_sort = r_sort;
        if (i_ctl.load) begin
            n_sort = r_store;
        end else if (i_ctl.sort) begin
            // lower of a pair keeps the minimum, upper keeps the maximum
            if (i_lower) begin
                n_sort = (i_right_sort < r_sort) ? i_right_sort : r_sort;
            end else begin
                n_sort = (i_left_sort > r_sort) ? i_left_sort : r_sort;
            end
        end else if (i_ctl.drain) begin
            n_sort = i_left_sort;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_store <= i_store_in;
        end
        r_sort <= n_sort;
    end

    assign o_store = r_store;
    assign o_sort  = r_sort;

endmodule

@@ design/tsfc_div.sv @@
// ----------------------------------------------------------------------------
// tsfc_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module tsfc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tsfc_pkg::DIVIDEND_W-1:0]  i_dividend,
    input  logic [tsfc_pkg::DIVISOR_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [tsfc_pkg::DIVIDEND_W-1:0]  o_quot
);
    import tsfc_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVIDEND_W-1:0] r_quot;
    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;

    assign w_trial = {r_rem, r_quot[DIVIDEND_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quot <= {r_quot[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ design/touch_sample_filter_calibrate_unit.sv @@
// X, Y and Z1 items are taken without a stall and give no result.
// A Z2 item stalls the input for the sort and drain passes over the cell row
// and, on a touch, for two runs of the bit-serial divider; the result is
// offered as the input frees up.
// Reset (synchronous, active low) restores the register defaults and clears
// held Z1 and control; the sample cells are not cleared.
// ----------------------------------------------------------------------------
// touch_sample_filter_calibrate_unit: touch sample filter and calibration
// Keeps the last SAMPLES X and Y readings in cell rows, takes a trimmed mean
// on Z2, forms pressure and maps the means to screen coordinates.
// ----------------------------------------------------------------------------
module touch_sample_filter_calibrate_unit #(
    parameter int SAMPLES = tsfc_pkg::SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tsfc_pkg::REG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsfc_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [tsfc_pkg::CHAN_W-1:0]     i_channel,
    input  logic [tsfc_pkg::REPLY_W-1:0]    i_reply_word,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_touched,
    output logic [tsfc_pkg::COORD_W-1:0]    o_screen_x,
    output logic [tsfc_pkg::COORD_W-1:0]    o_screen_y,
    output logic [tsfc_pkg::PRESS_W-1:0]    o_pressure
);
    import tsfc_pkg::*;

    localparam int CNT_W    = $clog2(SAMPLES);
    localparam int LO       = SAMPLES / 4;
    localparam int HI       = SAMPLES * 3 / 4;
    localparam int MEAN_CNT = HI - LO;
    localparam int SUM_W    = SAMPLE_W + $clog2(SAMPLES);
    localparam int REC_SH   = SUM_W + $clog2(MEAN_CNT);
    localparam longint REC_M = ((longint'(1) << REC_SH) + longint'(MEAN_CNT) - 1)
                               / longint'(MEAN_CNT);
    localparam logic [SUM_W:0]   REC_MUL  = (SUM_W + 1)'(REC_M);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);
    localparam logic [CNT_W-1:0] K_FIRST  = CNT_W'(SAMPLES - HI);
    localparam logic [CNT_W-1:0] K_LAST   = CNT_W'(SAMPLES - 1 - LO);

    // configuration
    logic [SAMPLE_W-1:0] r_x_origin, r_y_origin, r_x_span, r_y_span;
    logic [SAMPLE_W-1:0] r_width, r_height;
    logic [FLAGS_W-1:0]  r_flags;
    logic [PRESS_W-1:0]  r_thr;

    // sequencer and datapath
    t_state               r_state, n_state;
    t_op                  r_op;
    logic [CNT_W-1:0]     r_cnt;
    logic [SAMPLE_W-1:0]  r_z1;
    logic [PRESS_W-1:0]   r_pressure;
    logic [SUM_W-1:0]     r_sum_x, r_sum_y;
    logic [SAMPLE_W-1:0]  r_mean_x, r_mean_y;
    logic [DIVIDEND_W-1:0] r_prod;
    logic                 r_neg;
    logic [COORD_W-1:0]   r_sx, r_sy;

    // output register
    logic                 r_out_valid;
    logic                 r_out_touched;
    logic [COORD_W-1:0]   r_out_x, r_out_y;
    logic [PRESS_W-1:0]   r_out_press;

    logic                 w_in_acc;
    logic [SAMPLE_W-1:0]  w_sample;
    t_cell_ctl            w_ctl_x, w_ctl_y;
    logic                 w_odd_phase;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [DIVIDEND_W-1:0] w_div_quot;
    logic [DIVIDEND_W-1:0] w_dividend;
    logic [DIVISOR_W-1:0]  w_divisor;
    logic [SAMPLE_W-1:0]  w_w, w_h;
    logic                 w_touch;
    logic                 w_drain_take;
    logic                 w_out_free;
    logic [2*SUM_W:0]     w_mx_prod, w_my_prod;

    logic [SAMPLE_W-1:0]  w_xst [SAMPLES];
    logic [SAMPLE_W-1:0]  w_yst [SAMPLES];
    logic [SAMPLE_W-1:0]  w_xso [SAMPLES];
    logic [SAMPLE_W-1:0]  w_yso [SAMPLES];
    logic [SAMPLE_W-1:0]  w_xin [SAMPLES];
    logic [SAMPLE_W-1:0]  w_yin [SAMPLES];
    logic [SAMPLE_W-1:0]  w_xl  [SAMPLES];
    logic [SAMPLE_W-1:0]  w_yl  [SAMPLES];
    logic [SAMPLE_W-1:0]  w_xr  [SAMPLES];
    logic [SAMPLE_W-1:0]  w_yr  [SAMPLES];
    logic [SAMPLES-1:0]   w_lower;

    // product for the coordinate map
    logic [SAMPLE_W-1:0]  w_mul_mean, w_mul_origin, w_mul_size;
    logic [SAMPLE_W:0]    w_diff, w_mag;
    logic [2*SAMPLE_W-1:0] w_prod;
    logic [COORD_W-1:0]   w_clamped;
    logic [SAMPLE_W-1:0]  w_size_last;

    // finishing
    logic [SAMPLE_W-1:0]  w_w_last, w_h_last;
    logic [COORD_W-1:0]   w_fx, w_fy;

    assign w_sample    = i_reply_word[SAMPLE_LSB +: SAMPLE_W];
    assign o_stall     = r_state != S_IDLE;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_w         = fit_size(r_width);
    assign w_h         = fit_size(r_height);
    assign w_touch     = r_pressure >= r_thr;
    assign w_odd_phase = r_cnt[0];
    assign w_out_free  = !r_out_valid || !i_stall;

    // divide the middle sums by the constant count through a reciprocal product
    assign w_mx_prod   = r_sum_x * REC_MUL;
    assign w_my_prod   = r_sum_y * REC_MUL;

    // ---------------------------------------------------------------- cells
    for (genvar g = 0; g < SAMPLES; g++) begin : g_cell
        localparam bit G_ODD = (g % 2) == 1;

        assign w_lower[g] = G_ODD ^ w_odd_phase;

        if (g == 0) begin : g_first
            assign w_xin[g] = w_sample;
            assign w_yin[g] = w_sample;
            assign w_xl[g]  = '0;
            assign w_yl[g]  = '0;
        end else begin : g_inner_l
            assign w_xin[g] = w_xst[g-1];
            assign w_yin[g] = w_yst[g-1];
            assign w_xl[g]  = w_xso[g-1];
            assign w_yl[g]  = w_yso[g-1];
        end

        if (g == SAMPLES - 1) begin : g_last
            assign w_xr[g] = '1;
            assign w_yr[g] = '1;
        end else begin : g_inner_r
            assign w_xr[g] = w_xso[g+1];
            assign w_yr[g] = w_yso[g+1];
        end

        tsfc_cell u_xcell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl_x),
            .i_lower      (w_lower[g]),
            .i_store_in   (w_xin[g]),
            .i_left_sort  (w_xl[g]),
            .i_right_sort (w_xr[g]),
            .o_store      (w_xst[g]),
            .o_sort       (w_xso[g])
        );

        tsfc_cell u_ycell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl_y),
            .i_lower      (w_lower[g]),
            .i_store_in   (w_yin[g]),
            .i_left_sort  (w_yl[g]),
            .i_right_sort (w_yr[g]),
            .o_store      (w_yst[g]),
            .o_sort       (w_yso[g])
        );
    end

    // -------------------------------------------------------------- divider
    always_comb begin
        w_dividend = r_prod;
        case (r_op)
            OP_SX:   w_divisor = (r_x_span == '0) ? DIVISOR_W'(1) : r_x_span;
            default: w_divisor = (r_y_span == '0) ? DIVISOR_W'(1) : r_y_span;
        endcase
    end

    tsfc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // ------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_channel == CH_Z2) begin
                    n_state = S_SORT;
                end
            end
            S_SORT: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = w_touch ? S_MUL : S_FIN;
                end
            end
            S_DGO: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (w_div_done) begin
                    case (r_op)
                        OP_SX:   n_state = S_MUL;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_MUL: begin
                n_state = S_DGO;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // -------------------------------------------------------------- controls
    always_comb begin
        w_ctl_x       = '0;
        w_ctl_y       = '0;
        w_ctl_x.shift = w_in_acc && i_channel == CH_X;
        w_ctl_y.shift = w_in_acc && i_channel == CH_Y;
        w_ctl_x.load  = w_in_acc && i_channel == CH_Z2;
        w_ctl_y.load  = w_ctl_x.load;
        w_ctl_x.sort  = r_state == S_SORT;
        w_ctl_y.sort  = w_ctl_x.sort;
        w_ctl_x.drain = r_state == S_DRAIN;
        w_ctl_y.drain = w_ctl_x.drain;
        w_div_start   = r_state == S_DGO;
        w_drain_take  = (r_state == S_DRAIN) && (r_cnt >= K_FIRST) && (r_cnt <= K_LAST);
    end

    // ------------------------------------------------------- coordinate map
    always_comb begin
        w_mul_mean   = (r_op == OP_SY) ? r_mean_y   : r_mean_x;
        w_mul_origin = (r_op == OP_SY) ? r_y_origin : r_x_origin;
        w_mul_size   = (r_op == OP_SY) ? w_h        : w_w;
        w_diff       = {1'b0, w_mul_mean} - {1'b0, w_mul_origin};
        w_mag        = w_diff[SAMPLE_W] ? (~w_diff + 1'b1) : w_diff;
        w_prod       = w_mag[SAMPLE_W-1:0] * w_mul_size;
        w_size_last  = w_mul_size - SAMPLE_W'(1);
        // negative offsets truncate to zero or below: clamp to column zero
        if (r_neg) begin
            w_clamped = '0;
        end else if (w_div_quot >= DIVIDEND_W'(w_mul_size)) begin
            w_clamped = w_size_last[COORD_W-1:0];
        end else begin
            w_clamped = w_div_quot[COORD_W-1:0];
        end
    end

    always_comb begin
        w_w_last = w_w - SAMPLE_W'(1);
        w_h_last = w_h - SAMPLE_W'(1);
        w_fx     = r_flags[1] ? (w_w_last[COORD_W-1:0] - r_sx) : r_sx;
        w_fy     = r_flags[2] ? (w_h_last[COORD_W-1:0] - r_sy) : r_sy;
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_SX;
            r_cnt       <= '0;
            r_z1        <= '0;
            r_out_valid <= 1'b0;
            r_x_origin  <= X_ORIGIN_RST;
            r_y_origin  <= Y_ORIGIN_RST;
            r_x_span    <= X_SPAN_RST;
            r_y_span    <= Y_SPAN_RST;
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
            r_flags     <= FLAGS_RST;
            r_thr       <= THRESH_RST;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_X_ORIGIN: r_x_origin <= i_cfg_data[SAMPLE_W-1:0];
                    REG_Y_ORIGIN: r_y_origin <= i_cfg_data[SAMPLE_W-1:0];
                    REG_X_SPAN:   r_x_span   <= i_cfg_data[SAMPLE_W-1:0];
                    REG_Y_SPAN:   r_y_span   <= i_cfg_data[SAMPLE_W-1:0];
                    REG_WIDTH:    r_width    <= i_cfg_data[SAMPLE_W-1:0];
                    REG_HEIGHT:   r_height   <= i_cfg_data[SAMPLE_W-1:0];
                    REG_FLAGS:    r_flags    <= i_cfg_data[FLAGS_W-1:0];
                    default:      r_thr      <= i_cfg_data[PRESS_W-1:0];
                endcase
            end

            if (w_in_acc && i_channel == CH_Z1) begin
                r_z1 <= w_sample;
            end

            if (r_state == S_SORT || r_state == S_DRAIN) begin
                r_cnt <= (r_cnt == CNT_LAST) ? '0 : r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end

            if (r_state == S_IDLE) begin
                r_op <= OP_SX;
            end else if (r_state == S_DWAIT && w_div_done) begin
                r_op <= OP_SY;
            end

            // drop the output item once taken, reload it from the finish step
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_channel == CH_Z2) begin
            r_pressure <= (r_z1 != '0)
                ? (PRESS_W'(r_z1) + PRESS_W'(PRESS_BIAS) - PRESS_W'(w_sample))
                : '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (w_drain_take) begin
            r_sum_x <= r_sum_x + SUM_W'(w_xso[SAMPLES-1]);
            r_sum_y <= r_sum_y + SUM_W'(w_yso[SAMPLES-1]);
        end

        // the sums are complete by the last drain step
        if (r_state == S_DRAIN && r_cnt == CNT_LAST) begin
            r_mean_x <= w_mx_prod[REC_SH +: SAMPLE_W];
            r_mean_y <= w_my_prod[REC_SH +: SAMPLE_W];
        end

        if (r_state == S_MUL) begin
            r_prod <= w_prod[DIVIDEND_W-1:0];
            r_neg  <= w_diff[SAMPLE_W];
        end

        if (r_state == S_DWAIT && w_div_done) begin
            case (r_op)
                OP_SX:   r_sx <= w_clamped;
                default: r_sy <= w_clamped;
            endcase
        end

        if (r_state == S_FIN && w_out_free) begin
            r_out_press   <= r_pressure;
            r_out_touched <= w_touch;
            if (!w_touch) begin
                r_out_x <= '0;
                r_out_y <= '0;
            end else if (r_flags[0]) begin
                r_out_x <= w_fy;
                r_out_y <= w_fx;
            end else begin
                r_out_x <= w_fx;
                r_out_y <= w_fy;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_touched  = r_out_touched;
    assign o_screen_x = r_out_x;
    assign o_screen_y = r_out_y;
    assign o_pressure = r_out_press;

    // ----------------------------------------------------------- assertions
    a_untouched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_touched |-> o_screen_x == '0 && o_screen_y == '0)
        else $error("untouched item carries coordinates");

    a_touch_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_touched |-> o_pressure >= r_thr)
        else $error("touch reported below pressure threshold");

    a_sort_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SORT && r_cnt == '0 |-> $past(r_state) == S_IDLE)
        else $error("sort pass did not start from idle");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_FIN)
        else $error("output item raised outside finish step");

endmodule

@@ tb/touch_sample_filter_calibrate_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_sample_filter_calibrate_unit_tb: self-checking bench for the filter
// Drives tagged converter replies with random gaps, predicts the trimmed-mean
// calibration on every Z2 item and checks each result against the prediction.
// ----------------------------------------------------------------------------
module touch_sample_filter_calibrate_unit_tb;
    import tsfc_pkg::*;

    typedef struct packed {
        logic                 touched;
        logic [COORD_W-1:0]   sx;
        logic [COORD_W-1:0]   sy;
        logic [PRESS_W-1:0]   pressure;
    } t_touch;

    class touch_scoreboard;
        logic [SAMPLE_W-1:0] xs [SAMPLES_DEF];
        logic [SAMPLE_W-1:0] ys [SAMPLES_DEF];
        int unsigned xp, yp;
        logic [SAMPLE_W-1:0] z1;
        logic [CFG_W-1:0] regs [8];
        t_touch pending [$];
        int errors;

        function void clear();
            xp = 0; yp = 0; z1 = '0; errors = 0;
            foreach (xs[i]) begin xs[i] = '0; ys[i] = '0; end
            regs[REG_X_ORIGIN] = 13'd240; regs[REG_Y_ORIGIN] = 13'd285;
            regs[REG_X_SPAN] = 13'd3600; regs[REG_Y_SPAN] = 13'd3680;
            regs[REG_WIDTH] = 13'd320; regs[REG_HEIGHT] = 13'd240;
            regs[REG_FLAGS] = 13'd4; regs[REG_THRESH] = 13'd100;
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_W-1:0] v);
            regs[idx] = (idx == REG_FLAGS) ? (v & 13'h7) :
                        (idx == REG_THRESH) ? v : (v & 13'hFFF);
        endfunction

        function int mid_mean(logic [SAMPLE_W-1:0] st [SAMPLES_DEF]);
            int b [$];
            int sum;
            sum = 0;
            foreach (st[i]) b.push_back(st[i]);
            b.sort();
            for (int i = SAMPLES_DEF / 4; i < SAMPLES_DEF * 3 / 4; i++) sum += b[i];
            return sum / (SAMPLES_DEF / 2);
        endfunction

        function int limit_size(int s);
            return (s == 0) ? 1 : (s > SCREEN_MAX) ? SCREEN_MAX : s;
        endfunction

        function int to_screen(int raw, int org, int span, int size);
            int v;
            v = (raw - org) * size / ((span == 0) ? 1 : span);
            if (v < 0) v = 0;
            if (v >= size) v = size - 1;
            return v;
        endfunction

        function void note_item(t_channel ch, logic [REPLY_W-1:0] w);
            logic [SAMPLE_W-1:0] s;
            t_touch r;
            int rz, wd, ht, sx, sy;
            s = w[14:3];
            case (ch)
                CH_X: begin xs[xp] = s; xp = (xp + 1) % SAMPLES_DEF; end
                CH_Y: begin ys[yp] = s; yp = (yp + 1) % SAMPLES_DEF; end
                CH_Z1: z1 = s;
                default: begin
                    rz = (z1 != 0) ? (int'(z1) + PRESS_BIAS - int'(s)) : 0;
                    r = '0;
                    r.pressure = rz[PRESS_W-1:0];
                    if (rz >= int'(regs[REG_THRESH])) begin
                        wd = limit_size(regs[REG_WIDTH]);
                        ht = limit_size(regs[REG_HEIGHT]);
                        sx = to_screen(mid_mean(xs), regs[REG_X_ORIGIN], regs[REG_X_SPAN], wd);
                        sy = to_screen(mid_mean(ys), regs[REG_Y_ORIGIN], regs[REG_Y_SPAN], ht);
                        if (regs[REG_FLAGS][1]) sx = wd - 1 - sx;
                        if (regs[REG_FLAGS][2]) sy = ht - 1 - sy;
                        r.touched = 1'b1;
                        r.sx = regs[REG_FLAGS][0] ? sy[10:0] : sx[10:0];
                        r.sy = regs[REG_FLAGS][0] ? sx[10:0] : sy[10:0];
                    end
                    pending.push_back(r);
                end
            endcase
        endfunction

        function void check_result(t_touch got);
            t_touch e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.touched !== e.touched) begin
                $display("%0t: touched exp %0d got %0d", $time, e.touched, got.touched);
                errors++;
            end
            if (got.sx !== e.sx) begin
                $display("%0t: screen_x exp %0d got %0d", $time, e.sx, got.sx);
                errors++;
            end
            if (got.sy !== e.sy) begin
                $display("%0t: screen_y exp %0d got %0d", $time, e.sy, got.sy);
                errors++;
            end
            if (got.pressure !== e.pressure) begin
                $display("%0t: pressure exp %0d got %0d", $time, e.pressure, got.pressure);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_cfg_we = 0, i_valid = 0, i_stall = 0;
    logic [REG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic [CHAN_W-1:0] i_channel = '0;
    logic [REPLY_W-1:0] i_reply_word = '0;
    logic o_stall, o_valid, o_touched;
    logic [COORD_W-1:0] o_screen_x, o_screen_y;
    logic [PRESS_W-1:0] o_pressure;

    touch_scoreboard board;
    bit hold_off = 0;
    bit sink_on = 0;
    int sink_wait = 0;
    int n_sent = 0;

    touch_sample_filter_calibrate_unit uut (.*);

    always #1 i_clk = ~i_clk;

    // Receiver: stall for a random wait after each item, or hold off when asked
    always @(negedge i_clk) begin
        if (hold_off || !sink_on) begin
            i_stall <= 1'b1;
        end else if (sink_wait > 0) begin
            i_stall <= 1'b1;
            sink_wait--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_result({o_touched, o_screen_x, o_screen_y, o_pressure});
            sink_wait = $urandom_range(0, 7);
        end
    end

    // Hold the item until taken; valid stays up so the next item can follow
    task automatic send_item(t_channel ch, logic [REPLY_W-1:0] w);
        int gap;
        gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_channel <= ch;
        i_reply_word <= w;
        n_sent++;
        do @(posedge i_clk); while (o_stall);
        board.note_item(ch, w);
    endtask

    task automatic idle_in();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        board.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_out();
        idle_in();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic fill_stores();
        for (int i = 0; i < SAMPLES_DEF; i++) begin
            send_item(CH_X, REPLY_W'($urandom));
            send_item(CH_Y, REPLY_W'($urandom));
        end
    endtask

    // One touch sequence: a few X/Y, Z1 unless randomly skipped, Z2, centred readings
    task automatic touch_burst(bit noisy);
        int cx, cy, n;
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
        n = $urandom_range(1, SAMPLES_DEF);
        for (int i = 0; i < n; i++) begin
            send_item(CH_X, {1'($urandom_range(0, 1)),
                12'((cx + $urandom_range(0, 64) - 32) & 12'hFFF), 3'($urandom)});
            send_item(CH_Y, {1'($urandom_range(0, 1)),
                12'((cy + $urandom_range(0, 64) - 32) & 12'hFFF), 3'($urandom)});
        end
        if (noisy || ($urandom & 7) != 0) send_item(CH_Z1, REPLY_W'($urandom));
        send_item(CH_Z2, REPLY_W'($urandom));
    endtask

    task automatic random_config(bit extreme);
        logic [CFG_W-1:0] v;
        for (int r = 0; r < 8; r++) begin
            if (extreme) v = ($urandom & 1) ? '0 : '1;
            else if (r == REG_WIDTH || r == REG_HEIGHT) v = CFG_W'($urandom_range(0, 2200));
            else if (r == REG_THRESH) v = CFG_W'($urandom_range(0, 5000));
            else v = CFG_W'($urandom);
            write_reg(t_reg_idx'(r), v);
        end
    endtask

    initial begin
        #4000000;
        $display("touch_sample_filter_calibrate_unit_tb NOT OK");
        $finish;
    end

    initial begin
        board = new();
        board.clear();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        sink_on = 1;

        // Directed: reset defaults, extreme samples, zero Z1, all flag bits set
        fill_stores();
        send_item(CH_Z2, 16'h0000);
        send_item(CH_Z1, 16'hFFFF);
        send_item(CH_Z2, 16'h0000);
        send_item(CH_Z2, 16'hFFFF);
        send_item(CH_X, 16'h7FF8);
        send_item(CH_Y, 16'h8007);
        send_item(CH_Z1, 16'h0008);
        send_item(CH_Z2, 16'h7FF8);
        drain_out();
        write_reg(REG_X_SPAN, '0);
        write_reg(REG_Y_SPAN, '0);
        write_reg(REG_WIDTH, '0);
        write_reg(REG_HEIGHT, 13'hFFF);
        write_reg(REG_FLAGS, 13'd3);
        write_reg(REG_THRESH, '0);
        write_reg(REG_X_ORIGIN, 13'hFFF);
        write_reg(REG_Y_ORIGIN, '0);
        send_item(CH_Z2, 16'h1234);
        send_item(CH_Z1, 16'h4000);
        send_item(CH_Z2, 16'h4000);
        drain_out();
        write_reg(REG_THRESH, 13'h1FFF);
        write_reg(REG_FLAGS, 13'd7);
        send_item(CH_Z2, 16'h0000);
        drain_out();

        // Hold the receiver off while items keep coming
        hold_off = 1;
        fork
            begin
                for (int i = 0; i < 6; i++) touch_burst(0);
                idle_in();
            end
            begin
                repeat (1500) @(posedge i_clk);
                hold_off = 0;
            end
        join
        drain_out();

        while (n_sent < 1950) begin
            random_config(($urandom & 7) == 0);
            for (int k = 0; k < 25 && n_sent < 1950; k++) begin
                if (($urandom & 7) == 0) begin
                    send_item(t_channel'($urandom_range(0, 3)), REPLY_W'($urandom));
                end else begin
                    touch_burst(($urandom & 3) == 0);
                end
            end
            drain_out();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("touch_sample_filter_calibrate_unit_tb OK");
        else
            $display("touch_sample_filter_calibrate_unit_tb NOT OK");
        $finish;
    end
endmodule
